FILE: sv/mbd_pkg.sv
package mbd_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CNT_W      = $clog2(MAX_WIDTH);
  localparam int SIZE_W     = CNT_W + 1;
  localparam int CFG_SIZE_W = 13;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_ALPHA  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       level_done;
  } pix_out_t;

  typedef struct packed {
    logic [8:0] r;
    logic [8:0] g;
    logic [8:0] b;
    logic [8:0] a;
  } pair_t;

endpackage

FILE: sv/mipmap_box_downsample_core.sv
// 2x2 box-filter downsampler for one mip level, pixels in raster order.
// Throughput: one source pixel per cycle, sustained, with out_stall_i low.
// A result passes from the transfer of the pixel that closes a 2x2 block
// to out_valid_o through stage 1 (line-store read), then the output register.
// Reset: width 1, height 1, alpha on, position at level start; the line
// store is not cleared and is always written on an even row before use.
module mipmap_box_downsample_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mbd_pkg::PADDR_W-1:0]      paddr,
  input  logic [mbd_pkg::PDATA_W-1:0]      pwdata,
  output logic [mbd_pkg::PDATA_W-1:0]      prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  mbd_pkg::pix_in_t                 in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output mbd_pkg::pix_out_t                out_data_o
);
  import mbd_pkg::*;

  logic [CFG_SIZE_W-1:0] cfg_width_q, cfg_height_q;
  logic                  has_alpha_q;
  logic                  cfg_wr;
  reg_idx_e              cfg_idx;
  logic                  restart;

  logic [SIZE_W-1:0] w_eff, h_eff;
  logic [CNT_W-1:0]  dw, dh;
  logic              w1, h1;

  logic [CNT_W-1:0]  col_q, col_d, row_q, row_d;
  logic [SIZE_W-1:0] col_nx, row_nx;
  logic [31:0]       held_q;
  pix_in_t           px;
  pair_t             pair;
  logic [CNT_W-1:0]  x, y;
  logic              pair_ready, emit, last;
  logic              accept, wr_en, rd_en;
  logic [LINE_AW-1:0] addr;

  pair_t             line_mem [LINE_DEPTH];
  pair_t             rd_q;

  logic              s1_valid_q, s1_last_q, s1_h1_q;
  pair_t             s1_pair_q;
  logic              s1_move;
  pix_out_t          out_d;

  function automatic logic [7:0] box_avg(logic [8:0] up, logic [8:0] lo, logic dbl);
    logic [9:0] total;
    total = dbl ? {lo, 1'b0} : ({1'b0, up} + {1'b0, lo});
    return total[9:2];
  endfunction

  function automatic logic [SIZE_W-1:0] eff_size(logic [CFG_SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (32'(v) > MAX_WIDTH) begin
      r = SIZE_W'(MAX_WIDTH);
    end else begin
      r = SIZE_W'(v);
    end
    return r;
  endfunction

  // config port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_comb begin
    restart = 1'b0;
    prdata  = '0;
    case (cfg_idx)
      REG_WIDTH: begin
        restart = cfg_wr;
        prdata  = PDATA_W'(cfg_width_q);
      end
      REG_HEIGHT: begin
        restart = cfg_wr;
        prdata  = PDATA_W'(cfg_height_q);
      end
      REG_ALPHA: begin
        restart = cfg_wr;
        prdata  = PDATA_W'(has_alpha_q);
      end
      default: begin
        restart = 1'b0;
        prdata  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= CFG_SIZE_W'(1);
      cfg_height_q <= CFG_SIZE_W'(1);
      has_alpha_q  <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_WIDTH:  cfg_width_q  <= pwdata[CFG_SIZE_W-1:0];
        REG_HEIGHT: cfg_height_q <= pwdata[CFG_SIZE_W-1:0];
        REG_ALPHA:  has_alpha_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // geometry
  assign w_eff = eff_size(cfg_width_q);
  assign h_eff = eff_size(cfg_height_q);
  assign w1    = (w_eff == SIZE_W'(1));
  assign h1    = (h_eff == SIZE_W'(1));
  assign dw    = w1 ? CNT_W'(1) : CNT_W'(w_eff >> 1);
  assign dh    = h1 ? CNT_W'(1) : CNT_W'(h_eff >> 1);

  // handshake
  assign s1_move    = s1_valid_q & ~(out_valid_o & out_stall_i);
  assign in_stall_o = s1_valid_q & out_valid_o & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // horizontal pair and line-store access
  always_comb begin
    px          = in_data_i;
    if (!has_alpha_q) px.alpha_in = '0;
    x           = col_q >> 1;
    y           = row_q >> 1;
    addr        = x[LINE_AW-1:0];
    if (w1) begin
      pair.r = {px.red_in, 1'b0};
      pair.g = {px.green_in, 1'b0};
      pair.b = {px.blue_in, 1'b0};
      pair.a = {px.alpha_in, 1'b0};
    end else begin
      pair.r = {1'b0, held_q[31:24]} + {1'b0, px.red_in};
      pair.g = {1'b0, held_q[23:16]} + {1'b0, px.green_in};
      pair.b = {1'b0, held_q[15:8]}  + {1'b0, px.blue_in};
      pair.a = {1'b0, held_q[7:0]}   + {1'b0, px.alpha_in};
    end
    pair_ready = w1 | (col_q[0] & (x < dw));
    emit       = pair_ready & (h1 | row_q[0]);
    last       = (x == dw - CNT_W'(1)) & (y == dh - CNT_W'(1));
    wr_en      = accept & pair_ready & ~h1 & ~row_q[0] & (y < dh);
    rd_en      = accept & pair_ready & ~h1 & row_q[0];
  end

  // raster position
  always_comb begin
    col_nx = SIZE_W'(col_q) + SIZE_W'(1);
    row_nx = SIZE_W'(row_q) + SIZE_W'(1);
    col_d  = col_q;
    row_d  = row_q;
    if (restart) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (col_nx >= w_eff) begin
        col_d = '0;
        row_d = (row_nx >= h_eff) ? '0 : row_nx[CNT_W-1:0];
      end else begin
        col_d = col_nx[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      held_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (restart) begin
        held_q <= '0;
      end else if (accept && !w1 && !col_q[0]) begin
        held_q <= px;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) line_mem[addr] <= pair;
    if (rd_en) rd_q <= line_mem[addr];
  end

  // stage 1: pair waits for the line-store read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= emit;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pair_q <= pair;
      s1_last_q <= last;
      s1_h1_q   <= h1;
    end
  end

  always_comb begin
    out_d.red_out    = box_avg(rd_q.r, s1_pair_q.r, s1_h1_q);
    out_d.green_out  = box_avg(rd_q.g, s1_pair_q.g, s1_h1_q);
    out_d.blue_out   = box_avg(rd_q.b, s1_pair_q.b, s1_h1_q);
    out_d.alpha_out  = has_alpha_q ? box_avg(rd_q.a, s1_pair_q.a, s1_h1_q) : 8'd0;
    out_d.level_done = s1_last_q;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (s1_move) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) out_data_o <= out_d;
  end

endmodule

FILE: sv/mbd_checker.sv
module mbd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input mbd_pkg::pix_out_t out_data_o
);
  import mbd_pkg::*;

  // input stalls only behind a full, stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  // a new result follows an earlier pixel transfer, through stage 1 and the output register
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result appeared without a preceding input transfer");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind mipmap_box_downsample_core mbd_checker u_mbd_checker (.*);

FILE: tb/sv/tb_mipmap_box_downsample_core.sv
module tb_mipmap_box_downsample_core;
  timeunit 1ns;
  timeprecision 1ps;

  import mbd_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 950;

  typedef enum logic {ROW_PIX, ROW_CFG} row_kind_e;
  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    row_kind_e   kind;
    reg_idx_e    idx;
    logic [31:0] val;
    pix_in_t     px;
    logic        chk;
    pix_out_t    res;
  } dir_row_t;

  localparam dir_row_t DIRECTED_ROWS [0:34] = '{
    '{ROW_PIX, REG_WIDTH,  32'd0,    32'h0000_0000, 1'b1, {32'h0000_0000, 1'b1}},
    '{ROW_PIX, REG_WIDTH,  32'd0,    32'hffff_ffff, 1'b1, {32'hffff_ffff, 1'b1}},
    '{ROW_PIX, REG_WIDTH,  32'd0,    32'h5aa5_0ff0, 1'b1, {32'h5aa5_0ff0, 1'b1}},
    '{ROW_PIX, REG_WIDTH,  32'd0,    32'ha55a_f00f, 1'b1, {32'ha55a_f00f, 1'b1}},
    '{ROW_CFG, REG_ALPHA,  32'd0,    32'h0,         1'b0, 33'h0},
    '{ROW_PIX, REG_WIDTH,  32'd0,    32'h1234_5678, 1'b1, {32'h1234_5600, 1'b1}},
    '{ROW_CFG, REG_ALPHA,  32'd1,    32'h0,         1'b0, 33'h0},
    '{ROW_CFG, REG_WIDTH,  32'd2,    32'h0,         1'b0, 33'h0},
    '{ROW_CFG, REG_HEIGHT, 32'd2,    32'h0,         1'b0, 33'h0},
    '{ROW_PIX, REG_WIDTH,  32'd0,    32'hffff_ffff, 1'b0, 33'h0},
    '{ROW_PIX, REG_WIDTH,  32'd0,    32'hffff_ffff, 1'b0, 33'h0},
    '{ROW_PIX, REG_WIDTH,  32'd0,    32'hffff_ffff, 1'b0, 33'h0},
    '{ROW_PIX, REG_WIDTH,  32'd0,    32'hffff_ffff, 1'b1, {32'hffff_ffff, 1'b1}},
    // odd size: last column and row dropped
    '{ROW_CFG, REG_WIDTH,  32'd3,    32'h0,         1'b0, 33'h0},
    '{ROW_CFG, REG_HEIGHT, 32'd3,    32'h0,         1'b0, 33'h0},
    '{ROW_PIX, REG_WIDTH,  32'd0,    32'h01ff_0080, 1'b0, 33'h0},
    '{ROW_PIX, REG_WIDTH,  32'd0,    32'h02fe_0181, 1'b0, 33'h0},
    '{ROW_PIX, REG_WIDTH,  32'd0,    32'h0302_0104, 1'b0, 33'h0},
    '{ROW_PIX, REG_WIDTH,  32'd0,    32'h0001_0203, 1'b0, 33'h0},
    '{ROW_PIX, REG_WIDTH,  32'd0,    32'hfffe_fdfc, 1'b0, 33'h0},
    '{ROW_PIX, REG_WIDTH,  32'd0,    32'h7777_7777, 1'b0, 33'h0},
    '{ROW_PIX, REG_WIDTH,  32'd0,    32'h8888_8888, 1'b0, 33'h0},
    '{ROW_PIX, REG_WIDTH,  32'd0,    32'h9999_9999, 1'b0, 33'h0},
    '{ROW_PIX, REG_WIDTH,  32'd0,    32'haaaa_aaaa, 1'b0, 33'h0},
    // single column, then single row: replicated
    '{ROW_CFG, REG_WIDTH,  32'd1,    32'h0,         1'b0, 33'h0},
    '{ROW_CFG, REG_HEIGHT, 32'd2,    32'h0,         1'b0, 33'h0},
    '{ROW_PIX, REG_WIDTH,  32'd0,    32'h1020_3040, 1'b0, 33'h0},
    '{ROW_PIX, REG_WIDTH,  32'd0,    32'h3040_5061, 1'b0, 33'h0},
    '{ROW_CFG, REG_WIDTH,  32'd2,    32'h0,         1'b0, 33'h0},
    '{ROW_CFG, REG_HEIGHT, 32'd1,    32'h0,         1'b0, 33'h0},
    '{ROW_PIX, REG_WIDTH,  32'd0,    32'hfe01_807f, 1'b0, 33'h0},
    '{ROW_PIX, REG_WIDTH,  32'd0,    32'hff02_817f, 1'b0, 33'h0},
    // zero size acts as one
    '{ROW_CFG, REG_WIDTH,  32'd0,    32'h0,         1'b0, 33'h0},
    '{ROW_CFG, REG_HEIGHT, 32'd0,    32'h0,         1'b0, 33'h0},
    '{ROW_PIX, REG_WIDTH,  32'd0,    32'h80ff_017f, 1'b1, {32'h80ff_017f, 1'b1}}
  };

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 psel        = 1'b0;
  logic                 penable     = 1'b0;
  logic                 pwrite      = 1'b0;
  logic [PADDR_W-1:0]   paddr       = '0;
  logic [PDATA_W-1:0]   pwdata      = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  pix_in_t              in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  pix_out_t             out_data_o;

  mipmap_box_downsample_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  logic [12:0]  src_w;
  logic [12:0]  src_h;
  bit           alpha_on;
  int unsigned  col_pos;
  int unsigned  row_pos;
  int unsigned  held_px [4];
  int unsigned  pair_line [LINE_DEPTH][4];

  pix_out_t     box_mean_q [$];
  int           mismatch_count = 0;
  int unsigned  send_idle_pct  = 0;
  int unsigned  stall_pct      = 0;

  function automatic bit roll(input int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic int unsigned eff_size(input int unsigned v);
    if (v == 0) return 1;
    if (v > MAX_WIDTH) return MAX_WIDTH;
    return v;
  endfunction

  function automatic void restart_level();
    foreach (held_px[c]) held_px[c] = 0;
    col_pos = 0;
    row_pos = 0;
  endfunction

  function automatic bit predict_box_mean(input pix_in_t p, output pix_out_t r);
    int unsigned w, h, dw, dh, x, y;
    int unsigned px [4];
    int unsigned pair [4];
    int unsigned total [4];
    bit          ready;
    bit          emit;
    w = eff_size(src_w);
    h = eff_size(src_h);
    dw = (w > 1) ? w / 2 : 1;
    dh = (h > 1) ? h / 2 : 1;
    px = '{p.red_in, p.green_in, p.blue_in, p.alpha_in};
    if (!alpha_on) px[3] = 0;
    ready = 1'b0;
    emit = 1'b0;
    x = 0;
    y = 0;
    r = '0;
    if (w == 1) begin
      foreach (pair[c]) pair[c] = 2 * px[c];
      ready = 1'b1;
    end else if (col_pos % 2 == 1) begin
      foreach (pair[c]) pair[c] = held_px[c] + px[c];
      x = col_pos / 2;
      ready = x < dw;
    end else begin
      held_px = px;
    end
    if (ready && x < LINE_DEPTH) begin
      if (h == 1) begin
        foreach (total[c]) total[c] = 2 * pair[c];
        emit = 1'b1;
      end else if (row_pos % 2 == 0) begin
        if (row_pos / 2 < dh) pair_line[x] = pair;
      end else begin
        foreach (total[c]) total[c] = pair_line[x][c] + pair[c];
        y = row_pos / 2;
        emit = 1'b1;
      end
    end
    if (emit) begin
      r.red_out    = 8'(total[0] >> 2);
      r.green_out  = 8'(total[1] >> 2);
      r.blue_out   = 8'(total[2] >> 2);
      r.alpha_out  = alpha_on ? 8'(total[3] >> 2) : 8'h00;
      r.level_done = (x == dw - 1) && (y == dh - 1);
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
    return emit;
  endfunction

  function automatic pix_in_t rand_pixel();
    logic [7:0] ch [4];
    foreach (ch[c]) begin
      case ($urandom_range(9))
        0:       ch[c] = 8'h00;
        1:       ch[c] = 8'hff;
        default: ch[c] = 8'($urandom_range(255));
      endcase
    end
    return {ch[0], ch[1], ch[2], ch[3]};
  endfunction

  function automatic int unsigned pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return 0;
    if (r < 15) return 1;
    if (r < 75) return $urandom_range(2, 9);
    if (r < 95) return $urandom_range(10, 40);
    return $urandom_range(41, 128);
  endfunction

  task automatic set_mode(input idle_mode_e m);
    send_idle_pct = (m == IDLE_SEND) ? 45 : (m == IDLE_BOTH) ? 36 : 0;
    stall_pct     = (m == IDLE_RECV) ? 45 : (m == IDLE_BOTH) ? 36 : 0;
  endtask

  task automatic flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) flag_error($sformatf("mismatch %s: expected %0h, got %0h", name, want, got));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (box_mean_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] v);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_WIDTH:  src_w = v[12:0];
      REG_HEIGHT: src_h = v[12:0];
      REG_ALPHA:  alpha_on = v[0];
      default:    ;
    endcase
    restart_level();
  endtask

  task automatic send_pixel(input pix_in_t p, input bit chk, input pix_out_t typed);
    pix_out_t r;
    while (roll(send_idle_pct)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    do @(posedge clk_i); while (in_stall_o);
    if (predict_box_mean(p, r)) box_mean_q.push_back(chk ? typed : r);
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= roll(stall_pct);
  end

  always @(posedge clk_i) begin
    pix_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (box_mean_q.size() == 0) begin
        flag_error($sformatf("unexpected result %0h", out_data_o));
      end else begin
        want = box_mean_q.pop_front();
        check_field("red",   want.red_out,   out_data_o.red_out);
        check_field("green", want.green_out, out_data_o.green_out);
        check_field("blue",  want.blue_out,  out_data_o.blue_out);
        check_field("alpha", want.alpha_out, out_data_o.alpha_out);
        check_field("level_done", 8'(want.level_done), 8'(out_data_o.level_done));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int unsigned w, h, n, total, rand_items, phase;
    src_w    = 13'd1;
    src_h    = 13'd1;
    alpha_on = 1'b1;
    restart_level();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_mode(IDLE_NONE);
    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].kind == ROW_CFG) begin
        write_reg(DIRECTED_ROWS[i].idx, DIRECTED_ROWS[i].val);
      end else begin
        send_pixel(DIRECTED_ROWS[i].px, DIRECTED_ROWS[i].chk, DIRECTED_ROWS[i].res);
      end
    end

    // oversized sizes saturate; start of a wide row, cut off by the next write
    write_reg(REG_WIDTH, 32'd8191);
    write_reg(REG_HEIGHT, 32'd0);
    repeat (64) send_pixel(rand_pixel(), 1'b0, '0);
    write_reg(REG_HEIGHT, 32'd8191);
    write_reg(REG_WIDTH, 32'd2);
    repeat (8) send_pixel(rand_pixel(), 1'b0, '0);

    rand_items = 0;
    phase = 0;
    while (rand_items < RANDOM_ITEMS) begin
      set_mode(idle_mode_e'(phase % 4));
      w = pick_size();
      h = pick_size();
      if (eff_size(w) * eff_size(h) > 300) h = $urandom_range(1, 2);
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
      write_reg(REG_ALPHA, $urandom_range(1));
      n = eff_size(w) * eff_size(h);
      total = n * $urandom_range(1, 3);
      // cut-off level, restarted by the next register write
      if (n > 1 && $urandom_range(9) == 0) total += $urandom_range(1, n - 1);
      if (total > RANDOM_ITEMS - rand_items) total = RANDOM_ITEMS - rand_items;
      repeat (total) begin
        send_pixel(rand_pixel(), 1'b0, '0);
        rand_items++;
      end
      phase++;
    end

    drain();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
